FILE: hdl/bq_pkg.sv
// ----------------------------------------------------------------------------
// bq_pkg
// Shared constants, coefficient tables and types for the biquad cascade.
// ----------------------------------------------------------------------------
package bq_pkg;

	localparam int SECTIONS     = 3;
	localparam int SAMPLE_WIDTH = 16;
	localparam int DELAY_WIDTH  = 24;

	localparam int COEF_W    = 16;
	localparam int COEF_FRAC = 14;
	localparam int ROWS      = 3;

	localparam logic signed [COEF_W-1:0] GAIN_Q [ROWS] = '{16'sd8670, 16'sd8670, 16'sd13274};
	localparam logic signed [COEF_W-1:0] A1_Q   [ROWS] = '{-16'sd24255, 16'sd8587, -16'sd5148};
	localparam logic signed [COEF_W-1:0] A2_Q   [ROWS] = '{16'sd13740, 16'sd12329, -16'sd2905};
	localparam logic signed [COEF_W-1:0] B1_Q   [ROWS] = '{-16'sd6650, -16'sd17572, -16'sd12516};

	localparam int STEP_BITS = 3;
	localparam logic [STEP_BITS-1:0] STEP_GAIN = 3'd0;
	localparam logic [STEP_BITS-1:0] STEP_A1   = 3'd1;
	localparam logic [STEP_BITS-1:0] STEP_A2   = 3'd2;
	localparam logic [STEP_BITS-1:0] STEP_B1   = 3'd3;
	localparam logic [STEP_BITS-1:0] STEP_W    = 3'd4;
	localparam logic [STEP_BITS-1:0] STEP_Y    = 3'd5;

	typedef enum logic [1:0] {
		CELL_IDLE,
		CELL_RUN,
		CELL_DONE
	} bq_cell_state_t;

	typedef struct packed {
		logic valid;
		logic flag;
	} bq_hand_t;

endpackage

FILE: hdl/bq_cell.sv
// ----------------------------------------------------------------------------
// bq_cell
// One direct-form-II biquad section with its own delays and multiplier.
// ----------------------------------------------------------------------------
module bq_cell #(
	parameter int X_W = bq_pkg::DELAY_WIDTH,
	parameter int DW  = bq_pkg::DELAY_WIDTH,
	parameter int ROW = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bq_pkg::bq_hand_t      up,
	input  logic signed [X_W-1:0] x_in,
	output logic                  idle,
	input  logic                  down_ready,
	output bq_pkg::bq_hand_t      down,
	output logic signed [X_W-1:0] y_out
);

	localparam int CW    = bq_pkg::COEF_W;
	localparam int P_W   = X_W + CW;
	localparam int ACC_W = X_W + 3;

	localparam logic signed [CW-1:0] G_C  = bq_pkg::GAIN_Q[ROW];
	localparam logic signed [CW-1:0] A1_C = bq_pkg::A1_Q[ROW];
	localparam logic signed [CW-1:0] A2_C = bq_pkg::A2_Q[ROW];
	localparam logic signed [CW-1:0] B1_C = bq_pkg::B1_Q[ROW];

	localparam logic signed [P_W-1:0] HALF_LSB = P_W'(1) <<< (bq_pkg::COEF_FRAC - 1);
	localparam logic signed [ACC_W-1:0] D_MAX = {{(ACC_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] D_MIN = ~D_MAX;

	bq_pkg::bq_cell_state_t state_q, state_d;
	logic [bq_pkg::STEP_BITS-1:0] step_q;

	logic signed [X_W-1:0]   x_q;
	logic signed [DW-1:0]    w1_q, w2_q, y_q;
	logic signed [P_W-1:0]   prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    flag_q;

	logic signed [X_W-1:0]   mul_a;
	logic signed [CW-1:0]    mul_b;
	logic signed [P_W-1:0]   prod_d;
	logic signed [P_W-1:0]   rnd_full;
	logic signed [ACC_W-1:0] rnd;
	logic signed [DW-1:0]    w_sat, y_sat;
	logic                    w_clip, y_clip;
	logic signed [ACC_W-1:0] y_sum;
	logic                    take;

	assign take = up.valid && (state_q == bq_pkg::CELL_IDLE);

	always_comb begin
		case (step_q)
			bq_pkg::STEP_GAIN: begin
				mul_a = x_q;
				mul_b = G_C;
			end
			bq_pkg::STEP_A1: begin
				mul_a = X_W'(w1_q);
				mul_b = A1_C;
			end
			bq_pkg::STEP_A2: begin
				mul_a = X_W'(w2_q);
				mul_b = A2_C;
			end
			default: begin
				mul_a = X_W'(w1_q);
				mul_b = B1_C;
			end
		endcase
	end

	assign prod_d   = mul_a * mul_b;
	assign rnd_full = (prod_q + HALF_LSB) >>> bq_pkg::COEF_FRAC;
	assign rnd      = ACC_W'(rnd_full);

	always_comb begin
		w_clip = 1'b1;
		if (acc_q > D_MAX) begin
			w_sat = DW'(D_MAX);
		end else if (acc_q < D_MIN) begin
			w_sat = DW'(D_MIN);
		end else begin
			w_sat  = DW'(acc_q);
			w_clip = 1'b0;
		end
	end

	assign y_sat  = w_sat;
	assign y_clip = w_clip;
	assign y_sum  = ACC_W'(w_sat) + rnd + ACC_W'(w2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bq_pkg::CELL_IDLE;
			step_q  <= '0;
			w1_q    <= '0;
			w2_q    <= '0;
		end else begin
			state_q <= state_d;
			if (take) begin
				step_q <= '0;
			end else if (state_q == bq_pkg::CELL_RUN) begin
				step_q <= step_q + 1'b1;
				if (step_q == bq_pkg::STEP_W) begin
					w1_q <= w_sat;
					w2_q <= w1_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			x_q    <= x_in;
			flag_q <= up.flag;
		end else if (state_q == bq_pkg::CELL_RUN) begin
			case (step_q)
				bq_pkg::STEP_GAIN: begin
					prod_q <= prod_d;
				end
				bq_pkg::STEP_A1: begin
					acc_q  <= rnd;
					prod_q <= prod_d;
				end
				bq_pkg::STEP_A2, bq_pkg::STEP_B1: begin
					acc_q  <= acc_q - rnd;
					prod_q <= prod_d;
				end
				bq_pkg::STEP_W: begin
					acc_q  <= y_sum;
					flag_q <= flag_q | w_clip;
				end
				default: begin
					y_q    <= y_sat;
					flag_q <= flag_q | y_clip;
				end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bq_pkg::CELL_IDLE: begin
				if (up.valid) state_d = bq_pkg::CELL_RUN;
			end
			bq_pkg::CELL_RUN: begin
				if (step_q == bq_pkg::STEP_Y) state_d = bq_pkg::CELL_DONE;
			end
			bq_pkg::CELL_DONE: begin
				if (down_ready) state_d = bq_pkg::CELL_IDLE;
			end
			default: begin
				state_d = bq_pkg::CELL_IDLE;
			end
		endcase
	end

	assign idle       = (state_q == bq_pkg::CELL_IDLE);
	assign down.valid = (state_q == bq_pkg::CELL_DONE) && down_ready;
	assign down.flag  = flag_q;
	assign y_out      = X_W'(y_q);

	a_take_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		up.valid |-> (state_q == bq_pkg::CELL_IDLE))
		else $error("Transaction offered to a busy section.");

	a_start_run: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (state_q == bq_pkg::CELL_RUN) && (step_q == bq_pkg::STEP_GAIN))
		else $error("Section did not start its step sequence.");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bq_pkg::CELL_RUN) |-> (step_q <= bq_pkg::STEP_Y))
		else $error("Step counter ran past the last step.");

	a_leave_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bq_pkg::CELL_DONE) && !down_ready |=> (state_q == bq_pkg::CELL_DONE))
		else $error("Section dropped a result before the transaction.");

endmodule

FILE: hdl/biquad_cascade_iir_filter.sv
// ----------------------------------------------------------------------------
// biquad_cascade_iir_filter
// Cascade of direct-form-II biquad sections with a saturating output stage.
//
//   channel  | handshake           | payload
//   input    | in_valid, in_stall  | sample_in
//   output   | out_valid, out_stall| sample_out, saturated
//
// Each section works a sample in six steps, four of them multiplies on its own
// multiplier, and then holds it in its done state for the handoff.
// The first section takes a new sample only once it has handed on the last one
// and is idle again, so it sets the pace of the input.
// Reset clears all section delays and empties the chain and the output register.
// A stalled output holds its result while the chain keeps working; sections
// then wait in their done state until the next one is free.
// ----------------------------------------------------------------------------
module biquad_cascade_iir_filter #(
	parameter int SECTIONS     = bq_pkg::SECTIONS,
	parameter int SAMPLE_WIDTH = bq_pkg::SAMPLE_WIDTH,
	parameter int DELAY_WIDTH  = bq_pkg::DELAY_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	output logic                           saturated
);

	localparam int X_W = (SAMPLE_WIDTH > DELAY_WIDTH) ? SAMPLE_WIDTH : DELAY_WIDTH;
	localparam int E_W = X_W + 1;
	localparam logic signed [E_W-1:0] S_MAX = {{(E_W-SAMPLE_WIDTH+1){1'b0}},
		{(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [E_W-1:0] S_MIN = ~S_MAX;

	bq_pkg::bq_hand_t      hand [SECTIONS+1];
	logic signed [X_W-1:0] data [SECTIONS+1];
	logic                  idle [SECTIONS];
	logic                  out_free;

	logic signed [E_W-1:0]          last_ext;
	logic signed [SAMPLE_WIDTH-1:0] last_sat;
	logic                           last_clip;

	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;
	logic                           saturated_q;

	assign in_stall      = !idle[0];
	assign hand[0].valid = in_valid && idle[0];
	assign hand[0].flag  = 1'b0;
	assign data[0]       = X_W'(sample_in);
	assign out_free      = !out_valid_q || !out_stall;

	for (genvar s = 0; s < SECTIONS; s++) begin : g_cell
		logic ready_next;
		if (s == SECTIONS - 1) begin : g_last
			assign ready_next = out_free;
		end else begin : g_mid
			assign ready_next = idle[s+1];
		end
		bq_cell #(
			.X_W(X_W),
			.DW (DELAY_WIDTH),
			.ROW(s % bq_pkg::ROWS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.up        (hand[s]),
			.x_in      (data[s]),
			.idle      (idle[s]),
			.down_ready(ready_next),
			.down      (hand[s+1]),
			.y_out     (data[s+1])
		);
	end

	assign last_ext = E_W'(data[SECTIONS]);

	always_comb begin
		last_clip = 1'b1;
		if (last_ext > S_MAX) begin
			last_sat = SAMPLE_WIDTH'(S_MAX);
		end else if (last_ext < S_MIN) begin
			last_sat = SAMPLE_WIDTH'(S_MIN);
		end else begin
			last_sat  = SAMPLE_WIDTH'(last_ext);
			last_clip = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (hand[SECTIONS].valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hand[SECTIONS].valid) begin
			sample_out_q <= last_sat;
			saturated_q  <= hand[SECTIONS].flag | last_clip;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign saturated  = saturated_q;

endmodule
